[src/fpp_pkg.sv]
// Shared constants and functions for the falling particle pool.
// No dependencies.
package fpp_pkg;
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegXLow = 3'd0;
  localparam logic [RegIdxW-1:0] RegXHigh = 3'd1;
  localparam logic [RegIdxW-1:0] RegZLow = 3'd2;
  localparam logic [RegIdxW-1:0] RegZHigh = 3'd3;
  localparam logic [RegIdxW-1:0] RegSpeedLow = 3'd4;
  localparam logic [RegIdxW-1:0] RegSpeedHigh = 3'd5;
  localparam logic [RegIdxW-1:0] RegIntervalLow = 3'd6;
  localparam logic [RegIdxW-1:0] RegIntervalHigh = 3'd7;
  localparam logic [15:0] LfsrTaps = 16'hB400;
  localparam logic signed [15:0] DeathLimit = -16'sd512;

  function automatic logic [15:0] lfsr_next(input logic [15:0] r);
    lfsr_next = r[0] ? ((r >> 1) ^ LfsrTaps) : (r >> 1);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) sat16 = 16'sh7FFF;
    else if (v < -20'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction
endpackage

[src/falling_particle_pool.sv]
// Falling particle pool top level: sequencer, particle memory, free stack.
// Depends on fpp_pkg.
//
// Each accepted tick item runs a spawn burst when the burst timer fires, one pop per
// spawned particle (a pop on an empty free stack is skipped and spawns nothing), and
// then walks all N slots (default 64); stalls on the report side hold the walk. The
// walk is a read-modify-write over the particle memory: each slot is multiplied, then
// updated and written back while the next slot is read. The one shared 17x17 multiplier
// is used for every spawn product, one product per cycle except in the update step.
// The burst count comes from a constant reciprocal multiply. Slot reports leave through a
// single output register; the walk waits while that register is full and stalled.
// A new tick item is taken only after the last slot report is sent. Free-stack
// entries below the lowest fill level seen since reset were never pushed, and their
// own index is used in their place, so a low-water mark stands in for a clear pass;
// particle entries carry alive flip-flops and read as zero when dead.
module falling_particle_pool #(
  parameter int MAX_PARTICLES = 64,
  parameter int MIN_PER_BURST = 1,
  parameter int MAX_PER_BURST = 4,
  parameter int SPAWN_HEIGHT = 2560,
  parameter int LFSR_SEED = 44257
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [15:0] delta_time_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [5:0] slot_index_o,
  output logic slot_alive_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic last_slot_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [fpp_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import fpp_pkg::*;

  localparam int SW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int BRange = (MAX_PER_BURST >= MIN_PER_BURST) ?
                          (MAX_PER_BURST - MIN_PER_BURST + 1) : 1;
  // reciprocal of BRange, exact for every 16-bit draw
  localparam int RecipSh = 21;
  localparam longint RecipMul = ((longint'(1) << RecipSh) + longint'(BRange) - 1) /
                                longint'(BRange);

  localparam logic [3:0] StIdle = 4'd0, StTimer = 4'd1, StBurst = 4'd2,
    StPop = 4'd3, StPopRd = 4'd4, StMx = 4'd5, StMz = 4'd6, StMs = 4'd7,
    StSpWr = 4'd8, StIv = 4'd9, StIvWr = 4'd10, StRd = 4'd11,
    StUpd = 4'd12, StDone = 4'd13;

  logic [3:0] st_q, st_d;
  logic signed [15:0] xl_q, xh_q, zl_q, zh_q, sl_q, sh_q;
  logic [15:0] il_q, ih_q;
  logic [15:0] dt_q, rnd_q;
  logic signed [16:0] timer_q;
  logic [CW-1:0] fcnt_q, low_q;
  logic [4:0] burst_q;
  logic [SW-1:0] slot_q, sp_slot_q;
  logic [MAX_PARTICLES-1:0] alive_q;
  logic signed [15:0] px_q, pz_q;
  logic signed [33:0] prod_q;

  // particle memory (word is {speed, x, y, z}) and free stack
  logic [63:0] pmem [MAX_PARTICLES];
  logic [63:0] prd_q;
  logic [SW-1:0] fmem [MAX_PARTICLES];
  logic [SW-1:0] frd_q;

  logic ovalid_q;
  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xl_q <= -16'sd2560; xh_q <= 16'sd2560; zl_q <= -16'sd2560; zh_q <= 16'sd2560;
      sl_q <= -16'sd768; sh_q <= -16'sd256; il_q <= 16'd64;
      ih_q <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegXLow: xl_q <= cfg_data_i;
        RegXHigh: xh_q <= cfg_data_i;
        RegZLow: zl_q <= cfg_data_i;
        RegZHigh: zh_q <= cfg_data_i;
        RegSpeedLow: sl_q <= cfg_data_i;
        RegSpeedHigh: sh_q <= cfg_data_i;
        RegIntervalLow: il_q <= cfg_data_i;
        default: ih_q <= cfg_data_i;
      endcase
    end
  end

  assign in_stall_o = (st_q != StIdle);
  logic [15:0] rnd_n;
  assign rnd_n = lfsr_next(rnd_q);

  // shared multiplier operands: difference or speed (17 bit signed) times 17 bit signed
  logic signed [16:0] m_a, m_b;
  always_comb begin
    m_a = 17'sd0; m_b = 17'sd0;
    case (st_q)
      StPopRd: begin m_a = 17'(xh_q) - 17'(xl_q); m_b = $signed({1'b0, rnd_n}) - 17'sd32768; end
      StMx:    begin m_a = 17'(zh_q) - 17'(zl_q); m_b = $signed({1'b0, rnd_n}) - 17'sd32768; end
      StMz:    begin m_a = 17'(sh_q) - 17'(sl_q); m_b = $signed({1'b0, rnd_n}); end
      StIv:    begin m_a = $signed({1'b0, ih_q}) - $signed({1'b0, il_q});
                     m_b = $signed({1'b0, rnd_n}); end
      StRd:    begin m_a = 17'($signed(prd_q[63:48])); m_b = $signed({1'b0, dt_q}); end
      default: ;
    endcase
  end

  logic signed [19:0] upd_y;
  logic signed [15:0] new_y;
  logic slot_alive;
  logic [SW-1:0] slot_nx;
  assign slot_alive = alive_q[slot_q];
  assign slot_nx = (slot_q == SW'(MAX_PARTICLES - 1)) ? '0 : slot_q + SW'(1);
  assign upd_y = 20'($signed(prd_q[31:16])) + 20'(prod_q >>> 16);
  assign new_y = sat16(upd_y);

  // burst count: MIN_PER_BURST plus the draw modulo the burst range
  logic [4:0] nburst;
  logic [36:0] rq_prod;
  logic [15:0] rq_quo, rq_rem;
  assign rq_prod = 37'(rnd_n) * 37'(RecipMul);
  assign rq_quo = rq_prod[RecipSh +: 16];
  assign rq_rem = rnd_n - 16'(rq_quo * 16'(BRange));
  assign nburst = 5'(MIN_PER_BURST) + rq_rem[4:0];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_valid_i) st_d = StTimer;
      StTimer: st_d = (timer_q <= 17'sd0) ? StBurst : StRd;
      StBurst: st_d = StPop;
      StPop:   st_d = (burst_q == 5'd0) ? StIv : ((fcnt_q == '0) ? StPop : StPopRd);
      StPopRd: st_d = StMx;
      StMx:    st_d = StMz;
      StMz:    st_d = StMs;
      StMs:    st_d = StSpWr;
      StSpWr:  st_d = StPop;
      StIv:    st_d = StIvWr;
      StIvWr:  st_d = StRd;
      StRd:    st_d = StUpd;
      StUpd:   if (out_free) st_d = (slot_q == SW'(MAX_PARTICLES - 1)) ? StDone : StRd;
      StDone:  if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    // hold the move product while the report waits
    if (st_q != StUpd) prod_q <= m_a * m_b;
    prd_q <= pmem[(st_q == StUpd && out_free) ? slot_nx : slot_q];
    frd_q <= fmem[SW'(fcnt_q - CW'(1))];
    if (st_q == StMx) px_q <= sat16(20'(xl_q) + 20'(prod_q >>> 15));
    if (st_q == StMz) pz_q <= sat16(20'(zl_q) + 20'(prod_q >>> 15) + 20'(zh_q >>> 1));
    if (st_q == StMs)
      pmem[sp_slot_q] <= {16'(sat16(20'(sl_q) + 20'(prod_q >>> 16))), px_q,
                          16'(SPAWN_HEIGHT), pz_q};
    if (st_q == StUpd && out_free && slot_alive)
      pmem[slot_q] <= {prd_q[63:32], new_y, prd_q[15:0]};
    if (st_q == StUpd && out_free && slot_alive && new_y < DeathLimit &&
        fcnt_q < CW'(MAX_PARTICLES))
      fmem[SW'(fcnt_q)] <= slot_q;
    if (st_q == StUpd && out_free) begin
      slot_index_o <= 6'(slot_q);
      last_slot_o <= (slot_q == SW'(MAX_PARTICLES - 1));
      if (slot_alive && !(new_y < DeathLimit)) begin
        slot_alive_o <= 1'b1;
        pos_x_o <= prd_q[47:32]; pos_y_o <= new_y; pos_z_o <= prd_q[15:0];
      end else begin
        slot_alive_o <= 1'b0; pos_x_o <= '0; pos_y_o <= '0; pos_z_o <= '0;
      end
    end
  end

  // sequencer and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ovalid_q <= 1'b0; alive_q <= '0; fcnt_q <= CW'(MAX_PARTICLES);
      timer_q <= '0; rnd_q <= 16'(LFSR_SEED); slot_q <= '0; burst_q <= '0;
      sp_slot_q <= '0; dt_q <= '0; low_q <= CW'(MAX_PARTICLES);
    end else begin
      st_q <= st_d;
      if (out_free) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          dt_q <= delta_time_i;
          timer_q <= timer_q - 17'((17'(delta_time_i) + 17'd128) >> 8);
        end
        StBurst: begin rnd_q <= rnd_n; burst_q <= nburst; end
        StPop: if (burst_q != 5'd0) begin
          burst_q <= burst_q - 5'd1;
          if (fcnt_q != '0) fcnt_q <= fcnt_q - CW'(1);
        end
        StPopRd: begin
          // below the low-water mark the entry was never pushed: its own index is used
          if (fcnt_q < low_q) begin
            sp_slot_q <= SW'(fcnt_q);
            low_q <= fcnt_q;
          end else begin
            sp_slot_q <= frd_q;
          end
          rnd_q <= rnd_n;
        end
        StMx: rnd_q <= rnd_n;
        StMz: rnd_q <= rnd_n;
        StSpWr: alive_q[sp_slot_q] <= 1'b1;
        StIv: rnd_q <= rnd_n;
        StIvWr: timer_q <= 17'($signed({1'b0, il_q}) + 18'(prod_q >>> 16));
        StUpd: if (out_free) begin
          ovalid_q <= 1'b1;
          if (slot_alive && new_y < DeathLimit) begin
            alive_q[slot_q] <= 1'b0;
            if (fcnt_q < CW'(MAX_PARTICLES)) fcnt_q <= fcnt_q + CW'(1);
          end
          slot_q <= slot_nx;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CW'(MAX_PARTICLES)) else $error("free count overflow");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle) |-> (slot_q == '0)) else $error("walk not at slot zero");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_slot_o) |-> (slot_index_o == 6'(MAX_PARTICLES - 1)))
    else $error("last flag on wrong slot");
endmodule

[verif/fpp_checker.sv]
// Checker for the falling particle pool: watches the tick, report and register channels,
// predicts every slot report and compares field by field. Depends on fpp_pkg.
module fpp_checker #(
  parameter int MAX_PARTICLES = 64,
  parameter int MIN_PER_BURST = 1,
  parameter int MAX_PER_BURST = 4,
  parameter int SPAWN_HEIGHT = 2560,
  parameter int LFSR_SEED = 44257
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  logic [15:0] delta_time_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  logic [5:0] slot_index_i,
  input  logic slot_alive_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic last_slot_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic [fpp_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int fail_count_o,
  output int pending_o,
  output int reports_o
);
  import fpp_pkg::*;

  typedef struct packed {
    logic [5:0] index;
    logic alive;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic last;
  } slot_report_t;

  slot_report_t report_q[$];

  logic signed [15:0] regs[8];
  logic signed [15:0] px[64], py[64], pz[64], pspeed[64];
  logic live[64];
  logic [5:0] free_slots[64];
  int free_num;
  longint timer;
  logic [15:0] noise;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint roll();
    noise = noise[0] ? ((noise >> 1) ^ 16'hB400) : (noise >> 1);
    return longint'(noise);
  endfunction

  task automatic place_particle();
    longint f, d, vx, vz, vs;
    int slot;
    if (free_num == 0) return;
    free_num--;
    slot = free_slots[free_num];
    f = roll() - 32768;
    d = longint'(regs[RegXHigh]) - longint'(regs[RegXLow]);
    vx = longint'(regs[RegXLow]) + floor_sh(d * f, 15);
    f = roll() - 32768;
    d = longint'(regs[RegZHigh]) - longint'(regs[RegZLow]);
    vz = longint'(regs[RegZLow]) + floor_sh(d * f, 15) + floor_sh(longint'(regs[RegZHigh]), 1);
    d = longint'(regs[RegSpeedHigh]) - longint'(regs[RegSpeedLow]);
    vs = longint'(regs[RegSpeedLow]) + floor_sh(d * roll(), 16);
    px[slot] = clamp16(vx);
    py[slot] = clamp16(SPAWN_HEIGHT);
    pz[slot] = clamp16(vz);
    pspeed[slot] = clamp16(vs);
    live[slot] = 1'b1;
  endtask

  // Advance the pool by one tick and queue one report per slot.
  task automatic advance_pool(logic [15:0] dt);
    longint r, d, ny;
    int n;
    slot_report_t rep;
    timer -= (longint'(dt) + 128) >> 8;
    if (timer <= 0) begin
      r = roll();
      n = MIN_PER_BURST;
      if (MAX_PER_BURST >= MIN_PER_BURST)
        n = MIN_PER_BURST + int'(r % (MAX_PER_BURST - MIN_PER_BURST + 1));
      for (int k = 0; k < n; k++) place_particle();
      d = longint'(unsigned'(regs[RegIntervalHigh])) - longint'(unsigned'(regs[RegIntervalLow]));
      timer = longint'(unsigned'(regs[RegIntervalLow])) + floor_sh(d * roll(), 16);
    end
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      if (live[i]) begin
        ny = longint'(py[i]) + floor_sh(longint'(pspeed[i]) * longint'(dt), 16);
        py[i] = clamp16(ny);
        if (py[i] < -512) begin
          live[i] = 1'b0;
          if (free_num < MAX_PARTICLES) begin
            free_slots[free_num] = i[5:0];
            free_num++;
          end
        end
      end
      rep.index = i[5:0];
      rep.alive = live[i];
      rep.x = live[i] ? px[i] : '0;
      rep.y = live[i] ? py[i] : '0;
      rep.z = live[i] ? pz[i] : '0;
      rep.last = (i == MAX_PARTICLES - 1);
      report_q.insert(report_q.size(), rep);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_report_t want;
    if (!rst_ni) begin
      regs[RegXLow] = -16'sd2560;
      regs[RegXHigh] = 16'sd2560;
      regs[RegZLow] = -16'sd2560;
      regs[RegZHigh] = 16'sd2560;
      regs[RegSpeedLow] = -16'sd768;
      regs[RegSpeedHigh] = -16'sd256;
      regs[RegIntervalLow] = 16'sd64;
      regs[RegIntervalHigh] = 16'sd256;
      for (int k = 0; k < 64; k++) begin
        px[k] = '0; py[k] = '0; pz[k] = '0; pspeed[k] = '0;
        live[k] = 1'b0;
        free_slots[k] = k[5:0];
      end
      free_num = MAX_PARTICLES;
      timer = 0;
      noise = LFSR_SEED[15:0];
      report_q.delete();
      fail_count_o <= 0;
      reports_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) regs[cfg_index_i] = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        reports_o <= reports_o + 1;
        if (report_q.size() == 0) begin
          $error("slot report with nothing expected: slot %0d", slot_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = report_q.pop_front();
          if (want.index !== slot_index_i ||
              want.alive !== slot_alive_i || want.x !== pos_x_i ||
              want.y !== pos_y_i || want.z !== pos_z_i || want.last !== last_slot_i)
            fail_count_o <= fail_count_o + 1;
          if (want.index !== slot_index_i)
            $error("slot_index: expected %0d, got %0d", want.index, slot_index_i);
          if (want.alive !== slot_alive_i)
            $error("slot_alive: expected %0d, got %0d", want.alive, slot_alive_i);
          if (want.x !== pos_x_i)
            $error("pos_x: expected %0d, got %0d", want.x, pos_x_i);
          if (want.y !== pos_y_i)
            $error("pos_y: expected %0d, got %0d", want.y, pos_y_i);
          if (want.z !== pos_z_i)
            $error("pos_z: expected %0d, got %0d", want.z, pos_z_i);
          if (want.last !== last_slot_i)
            $error("last_slot: expected %0d, got %0d", want.last, last_slot_i);
        end
      end
      if (in_valid_i && !in_stall_i) advance_pool(delta_time_i);
    end
    pending_o <= report_q.size();
  end
endmodule

[verif/tb_falling_particle_pool.sv]
// Testbench top for the falling particle pool: drives tick items and register writes,
// stalls the report side at random and gives the verdict. Depends on fpp_pkg, fpp_checker.
module tb_falling_particle_pool;
  import fpp_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [15:0] delta_time_i;
  logic out_valid_o, out_stall_i;
  logic [5:0] slot_index_o;
  logic slot_alive_o, last_slot_o;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  int fail_count, pending, reports;
  int cycles;
  int ticks_sent;
  bit calm;  // when set, neither side idles

  falling_particle_pool i_dut (.*);

  fpp_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .delta_time_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .slot_index_i(slot_index_o), .slot_alive_i(slot_alive_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .last_slot_i(last_slot_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .reports_o(reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("falling_particle_pool test failed");
      $finish;
    end
  end

  // Stall the report side at random, about 38 percent of the time, except in calm stretches.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 38);
  end

  // Write one register and wait for its handshake.
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Send one tick item, idling at random first; hold until it is taken.
  task automatic send_tick(logic [15:0] dt);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    delta_time_i <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Drop valid, hold until every report is in, then let the walk settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] v[8]);
    for (int k = 0; k < 8; k++) write_reg(k[RegIdxW-1:0], v[k]);
    cfg_valid_i <= 1'b0;
  endtask

  // Random tick length: mostly frame-sized, sometimes extremes.
  function automatic logic [15:0] pick_dt();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(600, 4000));
    endcase
  endfunction

  initial begin
    logic [15:0] setting[8];
    ticks_sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    delta_time_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegXLow;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes of the tick time, burst timer at zero.
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h0080);
    send_tick(16'h007F);
    send_tick(16'h8000);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    drain();

    // Extremes: widest ranges, reversed ranges, fastest fall, long interval.
    setting = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    write_all(setting);
    repeat (6) send_tick(16'hFFFF);
    drain();
    // Reversed ranges, a reversed interval range and a tick time that rounds to zero on the timer.
    setting = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
    write_all(setting);
    repeat (8) send_tick(16'h0001);
    drain();
    // Zero speed and zero interval: a burst every tick.
    setting = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    write_all(setting);
    repeat (4) send_tick(16'h0200);
    drain();

    // Random phases with fresh settings; one of them without any idling.
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 8; k++) setting[k] = 16'($urandom);
      if (ph < 3) begin
        setting[RegSpeedLow] = 16'($urandom_range(0, 3000)) ^ 16'hFFFF;
        setting[RegSpeedHigh] = -16'sd64;
        setting[RegIntervalLow] = 16'($urandom_range(0, 40));
        setting[RegIntervalHigh] = 16'($urandom_range(0, 300));
      end
      write_all(setting);
      calm = (ph == 1);
      repeat (34) send_tick(pick_dt());
      drain();
    end
    calm = 1'b0;

    $display("covered %0d tick items and %0d slot reports under the reset settings",
             ticks_sent, reports);
    $display("and seven written register sets, with random and stall-free stretches");
    if (fail_count == 0) begin
      $display("falling_particle_pool test passed");
    end else begin
      $display("falling_particle_pool test failed");
    end
    $finish;
  end
endmodule

[files.f]
src/fpp_pkg.sv
src/falling_particle_pool.sv
verif/fpp_checker.sv
verif/tb_falling_particle_pool.sv
